@@ rtl/ehp_pkg.sv @@
// Shared types and constants for the Ethernet/IPv4/TCP-UDP header parser.
// No dependencies; imported by every module of the block.
package ehp_pkg;

  // Frame bytes at or beyond this position are not captured; the position counter holds there.
  localparam int MAX_FRAME_BYTES = 2048;
  localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

  // Byte positions within the frame
  localparam int POS_ETYPE_HI = 12;
  localparam int POS_ETYPE_LO = 13;
  localparam int POS_VER_IHL  = 14;
  localparam int POS_TTL      = 22;
  localparam int POS_PROTO    = 23;
  localparam int POS_ADDR     = 26;
  localparam int ADDR_BYTES   = 8;

  // Offsets within the transport header
  localparam int TP_SPORT_HI = 0;
  localparam int TP_SPORT_LO = 1;
  localparam int TP_DPORT_HI = 2;
  localparam int TP_DPORT_LO = 3;
  localparam int TP_ULEN_HI  = 4;
  localparam int TP_ULEN_LO  = 5;
  localparam int TP_FLAGS    = 13;
  localparam int TP_WIN_HI   = 14;
  localparam int TP_WIN_LO   = 15;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [7:0]  PROTO_TCP  = 8'h06;
  localparam logic [7:0]  PROTO_UDP  = 8'h11;
  localparam logic [7:0]  IHL_MASK   = 8'h0f;
  localparam logic [7:0]  VER_MASK   = 8'hf0;

  localparam logic [1:0] CLASS_OTHER = 2'd0;
  localparam logic [1:0] CLASS_IPV4  = 2'd1;
  localparam logic [1:0] CLASS_ARP   = 2'd2;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_TCP  = 2'd1;
  localparam logic [1:0] KIND_UDP  = 2'd2;

  localparam int RESULT_W   = 148;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] data_byte;
  } in_item_t;

  // Declared last field first so that frame_class lands in the lowest bits.
  typedef struct packed {
    logic [15:0] window_or_length;
    logic [5:0]  tcp_flags;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [31:0] dest_address;
    logic [31:0] source_address;
    logic [7:0]  ip_protocol;
    logic [7:0]  time_to_live;
    logic [5:0]  ip_header_bytes;
    logic [3:0]  ip_version;
    logic [1:0]  transport_kind;
    logic [1:0]  frame_class;
  } result_t;

endpackage

@@ rtl/ehp_in_stage.sv @@
// Input register of the header parser: holds one frame byte until the capture stage takes it.
// Depends on ehp_pkg.
module ehp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ehp_pkg::in_item_t in_item,
  input  logic            take,
  output logic            hold_valid,
  output ehp_pkg::in_item_t hold_item
);
  import ehp_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  // Accept whenever the register is empty or drains this cycle.
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

@@ rtl/ehp_capture.sv @@
// Capture stage: byte position counter, captured header fields and result decode.
// Depends on ehp_pkg.
module ehp_capture (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  ehp_pkg::in_item_t item,
  output ehp_pkg::result_t  result
);
  import ehp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt, cap_pos;
  logic [15:0]      etype_r, etype_nxt, cap_etype;
  logic [7:0]       ver_r, ver_nxt, cap_ver;
  logic [15:0]      ttlp_r, ttlp_nxt, cap_ttlp;
  logic [63:0]      addr_r, addr_nxt, cap_addr;
  logic [15:0]      sport_r, sport_nxt, cap_sport;
  logic [15:0]      dport_r, dport_nxt, cap_dport;
  logic [15:0]      wl_r, wl_nxt, cap_wl;
  logic [5:0]       flags_r, flags_nxt, cap_flags;

  logic [6:0]       tp_start;
  logic [POS_W-1:0] tp_off;
  logic             in_range;
  logic [7:0]       b;
  logic [7:0]       proto;
  logic [1:0]       fclass;
  logic [1:0]       tkind;

  assign b        = item.data_byte;
  assign in_range = pos_r < POS_W'(MAX_FRAME_BYTES);

  // Apply this byte to the captured fields.
  always_comb begin
    cap_pos   = pos_r;
    cap_etype = etype_r;
    cap_ver   = ver_r;
    cap_ttlp  = ttlp_r;
    cap_addr  = addr_r;
    cap_sport = sport_r;
    cap_dport = dport_r;
    cap_wl    = wl_r;
    cap_flags = flags_r;
    tp_start  = 7'd0;
    tp_off    = '0;
    if (in_range) begin
      cap_pos = pos_r + POS_W'(1);
      if (pos_r == POS_W'(POS_ETYPE_HI)) cap_etype[15:8] = b;
      if (pos_r == POS_W'(POS_ETYPE_LO)) cap_etype[7:0]  = b;
      if (pos_r == POS_W'(POS_VER_IHL))  cap_ver         = b;
      if (pos_r == POS_W'(POS_TTL))      cap_ttlp[15:8]  = b;
      if (pos_r == POS_W'(POS_PROTO))    cap_ttlp[7:0]   = b;
      for (int k = 0; k < ADDR_BYTES; k++) begin
        if (pos_r == POS_W'(POS_ADDR + k)) cap_addr[63 - 8 * k -: 8] = b;
      end
      // Transport header starts after the IP header, using IHL as captured so far.
      tp_start = 7'(POS_VER_IHL) + {1'b0, 4'(cap_ver & IHL_MASK), 2'b00};
      if (pos_r >= POS_W'(tp_start)) begin
        tp_off = pos_r - POS_W'(tp_start);
        case (tp_off)
          POS_W'(TP_SPORT_HI): cap_sport[15:8] = b;
          POS_W'(TP_SPORT_LO): cap_sport[7:0]  = b;
          POS_W'(TP_DPORT_HI): cap_dport[15:8] = b;
          POS_W'(TP_DPORT_LO): cap_dport[7:0]  = b;
          POS_W'(TP_ULEN_HI):  if (cap_ttlp[7:0] == PROTO_UDP) cap_wl[15:8] = b;
          POS_W'(TP_ULEN_LO):  if (cap_ttlp[7:0] == PROTO_UDP) cap_wl[7:0]  = b;
          POS_W'(TP_FLAGS):    cap_flags = b[5:0];
          POS_W'(TP_WIN_HI):   if (cap_ttlp[7:0] == PROTO_TCP) cap_wl[15:8] = b;
          POS_W'(TP_WIN_LO):   if (cap_ttlp[7:0] == PROTO_TCP) cap_wl[7:0]  = b;
          default: ;
        endcase
      end
    end
  end

  // Decode the result from the fields including this byte.
  assign proto = cap_ttlp[7:0];

  always_comb begin
    if (cap_etype == ETYPE_IPV4) begin
      fclass = CLASS_IPV4;
    end else if (cap_etype == ETYPE_ARP) begin
      fclass = CLASS_ARP;
    end else begin
      fclass = CLASS_OTHER;
    end
    tkind = KIND_NONE;
    if (fclass == CLASS_IPV4) begin
      if (proto == PROTO_TCP) begin
        tkind = KIND_TCP;
      end else if (proto == PROTO_UDP) begin
        tkind = KIND_UDP;
      end
    end
  end

  always_comb begin
    result.frame_class      = fclass;
    result.transport_kind   = tkind;
    result.ip_version       = 4'((cap_ver & VER_MASK) >> 4);
    result.ip_header_bytes  = {cap_ver[3:0], 2'b00};
    result.time_to_live     = cap_ttlp[15:8];
    result.ip_protocol      = proto;
    result.source_address   = cap_addr[63:32];
    result.dest_address     = cap_addr[31:0];
    result.source_port      = (tkind != KIND_NONE) ? cap_sport : 16'd0;
    result.dest_port        = (tkind != KIND_NONE) ? cap_dport : 16'd0;
    result.tcp_flags        = (tkind == KIND_TCP) ? cap_flags : 6'd0;
    result.window_or_length = (tkind != KIND_NONE) ? cap_wl : 16'd0;
  end

  // Hold when idle, commit on a byte, drop back to reset after the last byte.
  always_comb begin
    pos_nxt   = pos_r;
    etype_nxt = etype_r;
    ver_nxt   = ver_r;
    ttlp_nxt  = ttlp_r;
    addr_nxt  = addr_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    wl_nxt    = wl_r;
    flags_nxt = flags_r;
    if (take) begin
      if (item.last_byte) begin
        pos_nxt   = '0;
        etype_nxt = '0;
        ver_nxt   = '0;
        ttlp_nxt  = '0;
        addr_nxt  = '0;
        sport_nxt = '0;
        dport_nxt = '0;
        wl_nxt    = '0;
        flags_nxt = '0;
      end else begin
        pos_nxt   = cap_pos;
        etype_nxt = cap_etype;
        ver_nxt   = cap_ver;
        ttlp_nxt  = cap_ttlp;
        addr_nxt  = cap_addr;
        sport_nxt = cap_sport;
        dport_nxt = cap_dport;
        wl_nxt    = cap_wl;
        flags_nxt = cap_flags;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      etype_r <= '0;
      ver_r   <= '0;
      ttlp_r  <= '0;
      addr_r  <= '0;
      sport_r <= '0;
      dport_r <= '0;
      wl_r    <= '0;
      flags_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      etype_r <= etype_nxt;
      ver_r   <= ver_nxt;
      ttlp_r  <= ttlp_nxt;
      addr_r  <= addr_nxt;
      sport_r <= sport_nxt;
      dport_r <= dport_nxt;
      wl_r    <= wl_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule

@@ rtl/ehp_out_reg.sv @@
// Result register of the header parser: holds one decoded result until the sink takes it.
// Depends on ehp_pkg.
module ehp_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ehp_pkg::result_t result,
  output logic             out_valid,
  input  logic             out_ready,
  output ehp_pkg::result_t out_result
);
  import ehp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

@@ rtl/eth_ipv4_l4_header_parser.sv @@
// Top level of the Ethernet/IPv4/TCP-UDP header parser.
// Depends on ehp_pkg, ehp_in_stage, ehp_capture and ehp_out_reg.
//
// Frame bytes stream in on the in_ channel, one byte per transaction, starting at destination
// MAC byte 0, with in_tlast on the final byte. The parser accepts one byte every cycle: each
// byte passes an input register, then updates a saturating position counter and the captured
// header fields when the capture stage takes it. On the last byte one result transaction is
// written to the output register and all captured state returns to zero for the next frame;
// out_tvalid rises when that result enters the output register. The input side stalls only when a
// last byte reaches the capture stage while the previous result is still waiting on out_tready;
// ordinary bytes keep flowing while a result waits. Fields whose bytes the frame never reached
// read as zero, ports/window/length are zero unless the frame is IPv4 carrying TCP or UDP, and
// flags are zero unless TCP. Bytes at or beyond MAX_FRAME_BYTES are ignored.
module eth_ipv4_l4_header_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] data_byte
  input  logic                            in_tlast,   // last_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] frame_class, [3:2] transport_kind, [7:4] ip_version, [13:8] ip_header_bytes,
  // [21:14] time_to_live, [29:22] ip_protocol, [61:30] source_address,
  // [93:62] dest_address, [109:94] source_port, [125:110] dest_port,
  // [131:126] tcp_flags, [147:132] window_or_length, [151:148] zero
  output logic [ehp_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ehp_pkg::*;

  in_item_t in_item;
  in_item_t hold_item;
  logic     hold_valid;
  logic     take;
  logic     load;
  result_t  core_result;
  result_t  out_result;

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  // Advance the held byte unless it is a last byte and the result register cannot take it.
  assign take = hold_valid && !(hold_item.last_byte && out_tvalid && !out_tready);
  assign load = take && hold_item.last_byte;

  ehp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  ehp_capture u_capture (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .item   (hold_item),
    .result (core_result)
  );

  ehp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .result     (core_result),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {(OUT_TDATA_W - RESULT_W)'(0), out_result};

`ifndef SYNTHESIS
  // A last byte held behind a stalled result must stay in the input register.
  a_last_held: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid && hold_item.last_byte && out_tvalid && !out_tready) |=> hold_valid)
    else $error("last byte lost while result stalled");

  // Transport decoding only applies to IPv4 frames.
  a_kind_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_result.transport_kind != KIND_NONE) |->
      (out_result.frame_class == CLASS_IPV4))
    else $error("transport kind reported for non-IPv4 frame");

  // Flags are reported only for TCP.
  a_flags_tcp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_result.tcp_flags != 6'd0) |-> (out_result.transport_kind == KIND_TCP))
    else $error("tcp flags reported for non-TCP frame");

  // A result is written only when the result register is free or draining.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_tvalid || out_tready))
    else $error("result register overwritten");
`endif

endmodule
